// ===== rtl/bhbh_pkg.sv =====
package bhbh_pkg;

  localparam int MAX_FILTERS = 8;
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_BLOCK   = 32;

  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int HIST_DEPTH  = 256;

  localparam int RESP_W  = 16;
  localparam int CODE_W  = 8;
  localparam int COUNT_W = 11;
  localparam int NORM_W  = 25;
  localparam int NUM_W   = 35;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [NORM_W-1:0] NORM_LIMIT = 25'd16777216;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_FILTERS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FRD,
    S_HRD,
    S_HWR,
    S_BRD,
    S_DINIT,
    S_DIV,
    S_DONE_OK,
    S_DONE_BIN
  } state_t;

  typedef enum logic [1:0] {
    RES_OK,
    RES_ERR,
    RES_BIN
  } res_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     frame_wr;
    logic     build_start;
    logic     bin_latch;
    logic     frame_rd;
    logic     hist_rd;
    logic     hist_src_bin;
    logic     hist_wr;
    logic     div_start;
    logic     div_step;
    logic     out_load;
    res_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] mode;
    logic       ok;
    logic       out_free;
    logic       last;
    logic       div_done;
  } sts_t;

endpackage

// ===== rtl/bhbh_if.sv =====
interface bhbh_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [5:0]        row_index;
  logic [5:0]        col_index;
  logic [7:0]        bin_index;
  logic signed [15:0] resp_0;
  logic signed [15:0] resp_1;
  logic signed [15:0] resp_2;
  logic signed [15:0] resp_3;
  logic signed [15:0] resp_4;
  logic signed [15:0] resp_5;
  logic signed [15:0] resp_6;
  logic signed [15:0] resp_7;

  modport source (output valid, mode, row_index, col_index, bin_index,
                  resp_0, resp_1, resp_2, resp_3, resp_4, resp_5, resp_6, resp_7,
                  input ready);
  modport sink (input valid, mode, row_index, col_index, bin_index,
                resp_0, resp_1, resp_2, resp_3, resp_4, resp_5, resp_6, resp_7,
                output ready);
endinterface

interface bhbh_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [10:0] bin_count;
  logic [24:0] bin_normalized;

  modport source (output valid, status, bin_count, bin_normalized, input ready);
  modport sink (input valid, status, bin_count, bin_normalized, output ready);
endinterface

// ===== rtl/bhbh_ctrl.sv =====
module bhbh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  bhbh_pkg::sts_t sts,
  output bhbh_pkg::cmd_t cmd
);
  import bhbh_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.out_sel = RES_OK;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = sts.out_free;
        if (sts.in_valid && sts.out_free) begin
          priority if (sts.ok && sts.mode == MODE_WRITE) begin
            cmd.frame_wr = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_sel  = RES_OK;
          end else if (sts.ok && sts.mode == MODE_BUILD) begin
            cmd.build_start = 1'b1;
            state_next = S_FRD;
          end else if (sts.ok && sts.mode == MODE_READ) begin
            cmd.bin_latch = 1'b1;
            state_next = S_BRD;
          end else begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = RES_ERR;
          end
        end
      end
      S_FRD: begin
        cmd.frame_rd = 1'b1;
        state_next = S_HRD;
      end
      S_HRD: begin
        cmd.hist_rd = 1'b1;
        state_next = S_HWR;
      end
      S_HWR: begin
        cmd.hist_wr = 1'b1;
        state_next = sts.last ? S_DONE_OK : S_FRD;
      end
      S_BRD: begin
        cmd.hist_rd      = 1'b1;
        cmd.hist_src_bin = 1'b1;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_DONE_BIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DONE_OK: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = RES_OK;
          state_next = S_IDLE;
        end
      end
      S_DONE_BIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = RES_BIN;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/bhbh_dp.sv =====
module bhbh_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bhbh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bhbh_pkg::CFG_DATA_W-1:0]  cfg_data,
  bhbh_req_if.sink                         req,
  bhbh_rsp_if.source                       rsp,
  input  bhbh_pkg::cmd_t                   cmd,
  output bhbh_pkg::sts_t                   sts
);
  import bhbh_pkg::*;

  // configuration
  logic [3:0] nf_r;
  logic [5:0] bs_r, st_r;
  logic [6:0] w_r, h_r;
  logic [3:0] nf;
  logic [5:0] bs, step;
  logic [6:0] w, h;

  always_ff @(posedge clk) begin
    if (rst) begin
      nf_r <= 4'd8;
      bs_r <= 6'd8;
      st_r <= 6'd4;
      w_r  <= 7'd64;
      h_r  <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_FILTERS:  nf_r <= cfg_data[3:0];
        REG_BLOCK_SIZE:   bs_r <= cfg_data[5:0];
        REG_BLOCK_STEP:   st_r <= cfg_data[5:0];
        REG_IMAGE_WIDTH:  w_r  <= cfg_data;
        REG_IMAGE_HEIGHT: h_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    nf   = (nf_r == 4'd0) ? 4'd1 : ((nf_r > 4'd8) ? 4'd8 : nf_r);
    bs   = (bs_r == 6'd0) ? 6'd1 : ((bs_r > 6'd32) ? 6'd32 : bs_r);
    step = (st_r == 6'd0) ? 6'd1 : st_r;
    w    = (w_r == 7'd0) ? 7'd1 : ((w_r > 7'd64) ? 7'd64 : w_r);
    h    = (h_r == 7'd0) ? 7'd1 : ((h_r > 7'd64) ? 7'd64 : h_r);
  end

  // input decode and range checks
  logic signed [RESP_W-1:0] resp [MAX_FILTERS];
  logic [CODE_W-1:0] pos_bits, code;
  logic [11:0] r0_in, c0_in;
  logic ok_write, ok_build, ok_read;

  always_comb begin
    resp[0] = req.resp_0;
    resp[1] = req.resp_1;
    resp[2] = req.resp_2;
    resp[3] = req.resp_3;
    resp[4] = req.resp_4;
    resp[5] = req.resp_5;
    resp[6] = req.resp_6;
    resp[7] = req.resp_7;
    for (int j = 0; j < MAX_FILTERS; j++) begin
      pos_bits[CODE_W-1-j] = (resp[j] > 16'sd0);
    end
    // filter 0 lands at the MSB of an nf-bit code
    code = pos_bits >> (4'd8 - nf);
    r0_in = 12'(req.row_index) * 12'(step);
    c0_in = 12'(req.col_index) * 12'(step);
    ok_write = (7'(req.row_index) < h) && (7'(req.col_index) < w);
    ok_build = ((13'(r0_in) + 13'(bs)) <= 13'(h)) && ((13'(c0_in) + 13'(bs)) <= 13'(w));
    ok_read  = 9'(req.bin_index) < (9'd1 << nf);
  end

  // frame store
  logic [CODE_W-1:0] frame [FRAME_DEPTH];
  logic [CODE_W-1:0] frd;
  logic [5:0] r0, c0;
  logic [4:0] m, l;
  logic [5:0] prow, pcol;

  assign prow = 6'(7'(r0) + 7'(m));
  assign pcol = 6'(7'(c0) + 7'(l));

  always_ff @(posedge clk) begin
    if (cmd.frame_wr) begin
      frame[{req.row_index, req.col_index}] <= code;
    end
    if (cmd.frame_rd) begin
      frd <= frame[{prow, pcol}];
    end
  end

  // block scan counters
  logic [4:0] bs_last;
  assign bs_last = 5'(bs - 6'd1);

  always_ff @(posedge clk) begin
    if (cmd.build_start) begin
      r0 <= r0_in[5:0];
      c0 <= c0_in[5:0];
      m  <= '0;
      l  <= '0;
    end else if (cmd.hist_wr) begin
      if (l == bs_last) begin
        l <= '0;
        m <= m + 5'd1;
      end else begin
        l <= l + 5'd1;
      end
    end
  end

  // histogram store; an entry without its valid bit reads as zero
  logic [COUNT_W-1:0] hist [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_vld;
  logic [COUNT_W-1:0] hrd;
  logic [CODE_W-1:0] haddr, bin_r, hsel;

  assign hsel = cmd.hist_src_bin ? bin_r : frd;

  always_ff @(posedge clk) begin
    if (cmd.bin_latch) begin
      bin_r <= req.bin_index;
    end
    if (cmd.hist_rd) begin
      haddr <= hsel;
      hrd   <= hist_vld[hsel] ? hist[hsel] : '0;
    end
    if (cmd.hist_wr) begin
      hist[haddr] <= hrd + 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.build_start) begin
      hist_vld <= '0;
    end else if (cmd.hist_wr) begin
      hist_vld[haddr] <= 1'b1;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [NUM_W-1:0] quo;
  logic [11:0] rem, rem_sh;
  logic [10:0] den;
  logic [5:0] dcnt;
  logic ge;

  assign rem_sh = {rem[10:0], quo[NUM_W-1]};
  assign ge = rem_sh >= 12'(den);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo  <= NUM_W'(hrd) << (5'(nf) + 5'd16);
      rem  <= '0;
      den  <= 11'(bs) * 11'(bs);
      dcnt <= 6'(NUM_W);
    end else if (cmd.div_step) begin
      rem  <= ge ? (rem_sh - 12'(den)) : rem_sh;
      quo  <= {quo[NUM_W-2:0], ge};
      dcnt <= dcnt - 6'd1;
    end
  end

  // result register
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_sel)
        RES_OK: begin
          rsp.status         <= 1'b0;
          rsp.bin_count      <= '0;
          rsp.bin_normalized <= '0;
        end
        RES_BIN: begin
          rsp.status         <= 1'b0;
          rsp.bin_count      <= hrd;
          rsp.bin_normalized <= (quo > NUM_W'(NORM_LIMIT)) ? NORM_LIMIT : quo[NORM_W-1:0];
        end
        default: begin
          rsp.status         <= 1'b1;
          rsp.bin_count      <= '0;
          rsp.bin_normalized <= '0;
        end
      endcase
    end
  end

  assign rsp.valid = out_valid;
  assign req.ready = cmd.in_ready;

  always_comb begin
    sts.in_valid = req.valid;
    sts.mode     = req.mode;
    unique case (req.mode)
      MODE_WRITE: sts.ok = ok_write;
      MODE_BUILD: sts.ok = ok_build;
      MODE_READ:  sts.ok = ok_read;
      default:    sts.ok = 1'b0;
    endcase
    sts.out_free = !out_valid || rsp.ready;
    sts.last     = (l == bs_last) && (m == bs_last);
    sts.div_done = (dcnt == 6'd0);
  end

endmodule

// ===== rtl/binary_hash_block_histogram_core.sv =====
// Binary hashing and block histogram. A pixel write (mode 0) or any request
// that fails its range check is answered straight from the idle state, so
// such items can follow each other every cycle while the result register
// drains. In a block build (mode 1) each pixel is a frame read, a histogram
// read and a histogram write on the single-port stores, and the histogram is
// cleared at once through per-bin valid bits. A bin read (mode 2) runs the
// 35-step restoring divider that forms the Q9.16 value.
// The frame store is not cleared; build only over pixels already written.
module binary_hash_block_histogram_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bhbh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bhbh_pkg::CFG_DATA_W-1:0]  cfg_data,
  bhbh_req_if.sink                         req,
  bhbh_rsp_if.source                       rsp
);
  import bhbh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bhbh_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  bhbh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
